>>> sv/dle_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// dle_frame_receiver_defines.svh
// Assertion macros for the DLE frame receiver. Both macros use the clock
// i_clk and the active-low reset i_rst_n of the module that includes this file.
// ----------------------------------------------------------------------------
`ifndef DLE_FRAME_RECEIVER_DEFINES_SVH
`define DLE_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH

// the property holds in the same cycle
`define DFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("dle_frame_receiver: assertion failed");

// the property holds in the next cycle
`define DFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("dle_frame_receiver: assertion failed");

`else

`define DFR_ASSERT_NOW(label, ante, cons)
`define DFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and constants shared by the DLE frame receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfr_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_STX_CHAR      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ETX_CHAR      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DLE_ENABLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CR_STRIP      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOD_EOD_MODE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOD_EOD_TABLE = 3'd5;

    localparam logic [7:0]  RST_STX_CHAR = 8'h02;
    localparam logic [7:0]  RST_ETX_CHAR = 8'h03;

    localparam logic [7:0]  CH_DLE      = 8'h10;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_PRINT_LO = 8'h20;
    localparam logic [7:0]  CH_PRINT_HI = 8'h7E;

    localparam int LEN_W = 13;

    typedef struct packed {
        logic [7:0]  stx_char;
        logic [7:0]  etx_char;
        logic        dle_enable;
        logic        cr_strip_enable;
        logic        sod_eod_mode;
        logic [63:0] sod_eod_table;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             frame_end;
        logic [LEN_W-1:0] frame_length;
        logic [LEN_W-1:0] first_nonprint_pos;
        logic [1:0]       frame_type;
        logic             cr_dropped;
    } t_result;

endpackage

>>> sv/dfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfr_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_cfg_regs
    import dfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    output logic                   o_cfg_ready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stx_char        <= RST_STX_CHAR;
            r_cfg.etx_char        <= RST_ETX_CHAR;
            r_cfg.dle_enable      <= 1'b1;
            r_cfg.cr_strip_enable <= 1'b0;
            r_cfg.sod_eod_mode    <= 1'b0;
            r_cfg.sod_eod_table   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STX_CHAR:      r_cfg.stx_char        <= i_cfg_data[7:0];
                CFG_ETX_CHAR:      r_cfg.etx_char        <= i_cfg_data[7:0];
                CFG_DLE_ENABLE:    r_cfg.dle_enable      <= i_cfg_data[0];
                CFG_CR_STRIP:      r_cfg.cr_strip_enable <= i_cfg_data[0];
                CFG_SOD_EOD_MODE:  r_cfg.sod_eod_mode    <= i_cfg_data[0];
                CFG_SOD_EOD_TABLE: r_cfg.sod_eod_table   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/dfr_core.sv
// ----------------------------------------------------------------------------
// dfr_core
// Frame state machine: start code lookup, DLE unescape, one-byte hold for
// trailing CR removal, length and first non-printable position tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_core
    import dfr_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 4096,
    parameter int DEVICE_TYPES  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int CW = $clog2(MAX_FRAME_LEN + 2);
    localparam int LW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_FRAME_LEN + 1);
    localparam logic [CW-1:0] LEN_MAX   = CW'(MAX_FRAME_LEN);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STX  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_EOD  = 4'b1000
    } t_phase;

    function automatic logic [LW-1:0] f_sat(input logic [CW-1:0] v);
        return (v > LEN_MAX) ? LW'(LEN_MAX) : LW'(v);
    endfunction

    t_phase        r_phase, n_phase;
    logic          r_escape, n_escape;
    logic [7:0]    r_end_code, n_end_code;
    logic [1:0]    r_type, n_type;
    logic [7:0]    r_held, n_held;
    logic          r_held_valid, n_held_valid;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_nonprint, n_nonprint;

    logic          hit;
    logic [7:0]    hit_end;
    logic [1:0]    hit_type;
    logic          strip;
    logic [CW-1:0] fin_count;
    logic [LW-1:0] fin_len;
    logic [LW-1:0] fin_np;
    logic          do_store;
    logic          do_finish;
    logic          nonprint;

    always_comb begin
        hit      = 1'b0;
        hit_end  = '0;
        hit_type = '0;
        for (int i = DEVICE_TYPES - 1; i >= 0; i--) begin
            if (i_cfg.sod_eod_table[16*i+8 +: 8] != 8'h00 &&
                i_cfg.sod_eod_table[16*i +: 8] == i_rx_byte) begin
                hit      = 1'b1;
                hit_end  = i_cfg.sod_eod_table[16*i+8 +: 8];
                hit_type = 2'(i);
            end
        end
    end

    assign strip     = r_held_valid && i_cfg.cr_strip_enable && (r_held == CH_CR);
    assign fin_count = strip ? (r_count - 1'b1) : r_count;
    assign fin_len   = f_sat(fin_count);
    assign fin_np    = (strip && r_nonprint == fin_len) ? '0 : r_nonprint;
    assign nonprint  = (i_rx_byte < CH_PRINT_LO) || (i_rx_byte > CH_PRINT_HI);

    always_comb begin
        n_phase      = r_phase;
        n_escape     = r_escape;
        n_end_code   = r_end_code;
        n_type       = r_type;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_count      = r_count;
        n_nonprint   = r_nonprint;
        do_store     = 1'b0;
        do_finish    = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_cfg.sod_eod_mode) begin
                    if (hit) begin
                        n_end_code = hit_end;
                        n_type     = hit_type;
                        n_phase    = PH_STX;
                    end
                end else if (i_rx_byte == i_cfg.stx_char) begin
                    n_type  = '0;
                    n_phase = PH_BODY;
                end
            end
            PH_STX: begin
                if (i_rx_byte == i_cfg.stx_char) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_rx_byte == i_cfg.etx_char && !r_escape) begin
                    if (i_cfg.sod_eod_mode) begin
                        n_phase = PH_EOD;
                    end else begin
                        do_finish = 1'b1;
                    end
                end else if (i_cfg.dle_enable && !r_escape && i_rx_byte == CH_DLE) begin
                    n_escape = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_EOD: begin
                if (i_rx_byte == r_end_code) begin
                    do_finish = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (do_store) begin
            if (r_nonprint == '0 && nonprint) begin
                n_nonprint = f_sat(r_count);
            end
            o_res_valid      = r_held_valid;
            o_res.out_byte   = r_held;
            o_res.byte_valid = 1'b1;
            n_held           = i_rx_byte;
            n_held_valid     = 1'b1;
            if (r_count < CNT_LIMIT) begin
                n_count = r_count + 1'b1;
            end
            n_escape = 1'b0;
        end

        if (do_finish) begin
            o_res_valid              = 1'b1;
            o_res.out_byte           = (r_held_valid && !strip) ? r_held : 8'h00;
            o_res.byte_valid         = r_held_valid && !strip;
            o_res.frame_end          = 1'b1;
            o_res.frame_length       = LEN_W'(fin_len);
            o_res.first_nonprint_pos = LEN_W'(fin_np);
            o_res.frame_type         = r_type;
            o_res.cr_dropped         = strip;
            n_phase                  = PH_IDLE;
            n_escape                 = 1'b0;
            n_held                   = '0;
            n_held_valid             = 1'b0;
            n_count                  = '0;
            n_nonprint               = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_escape     <= 1'b0;
            r_end_code   <= '0;
            r_type       <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_count      <= '0;
            r_nonprint   <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_escape     <= n_escape;
            r_end_code   <= n_end_code;
            r_type       <= n_type;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_count      <= n_count;
            r_nonprint   <= n_nonprint;
        end
    end

endmodule

>>> sv/dfr_out_stage.sv
// ----------------------------------------------------------------------------
// dfr_out_stage
// Result register; holds an item until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_out_stage
    import dfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    input  logic    i_out_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;

    assign o_free  = !r_valid || i_out_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

endmodule

>>> sv/dle_frame_receiver.sv
// ----------------------------------------------------------------------------
// dle_frame_receiver
// STX/ETX frame receiver with DLE unescape, optional start/end-of-data codes
// and trailing CR removal.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the output side keeps up. A byte is
// captured in an input register and runs through the frame state machine;
// its result, if any, is then registered in the output register. Body bytes
// come out one byte behind the input so that a CR ending the body can be
// dropped; the frame's last body byte leaves with the end-of-frame result
// that carries length, first non-printable position and type. Configuration
// is written through a separate port; the user must write it only while no
// item is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dle_frame_receiver_defines.svh"

module dle_frame_receiver
    import dfr_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 4096,
    parameter int DEVICE_TYPES  = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_rx_byte,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_frame_end,
    output logic [LEN_W-1:0]       o_frame_length,
    output logic [LEN_W-1:0]       o_first_nonprint_pos,
    output logic [1:0]             o_frame_type,
    output logic                   o_cr_dropped
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_data;

    dfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    dfr_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .DEVICE_TYPES  (DEVICE_TYPES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_rx_byte   (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && res_valid),
        .i_data      (res),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_data      (out_data)
    );

    assign o_out_byte           = out_data.out_byte;
    assign o_byte_valid         = out_data.byte_valid;
    assign o_frame_end          = out_data.frame_end;
    assign o_frame_length       = out_data.frame_length;
    assign o_first_nonprint_pos = out_data.first_nonprint_pos;
    assign o_frame_type         = out_data.frame_type;
    assign o_cr_dropped         = out_data.cr_dropped;

    `DFR_ASSERT_NEXT(a_in_hold, r_in_valid && !out_free, r_in_valid && $stable(r_in_byte))
    `DFR_ASSERT_NOW(a_no_overrun, r_in_valid && !out_free, !o_in_ready)
    `DFR_ASSERT_NOW(a_empty_is_end, o_out_valid && !o_byte_valid, o_frame_end)
    `DFR_ASSERT_NOW(a_strip_no_byte, o_out_valid && o_cr_dropped, !o_byte_valid && o_frame_end)

endmodule

>>> verif/dle_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// dle_frame_receiver_test
// Self-checking bench for the DLE frame receiver. Drives received bytes and
// register writes over their handshakes and keeps its own deframer alongside
// the block. Every result is checked field by field against the oldest
// predicted one. Directed frames cover the corner cases, then random
// phases with fresh settings run well-formed, cut and noisy frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dle_frame_receiver_test;
    import dfr_pkg::*;

    localparam int MAX_LEN   = 4096;
    localparam int DEV_TYPES = 4;
    localparam int ITEM_GOAL = 1500;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_WAIT_STX,
        RX_BODY,
        RX_WAIT_EOD
    } t_rx_phase;

    class deframe_scoreboard;
        t_cfg        cfg;
        t_rx_phase   phase;
        bit          esc_pending;
        logic [7:0]  end_code;
        logic [1:0]  ftype;
        logic [7:0]  held;
        bit          held_ok;
        int unsigned count;
        int unsigned np_pos;
        t_result     pending_results[$];
        int          errors;

        function new();
            cfg.stx_char        = RST_STX_CHAR;
            cfg.etx_char        = RST_ETX_CHAR;
            cfg.dle_enable      = 1'b1;
            cfg.cr_strip_enable = 1'b0;
            cfg.sod_eod_mode    = 1'b0;
            cfg.sod_eod_table   = '0;
            end_code = 8'h00;
            ftype    = 2'd0;
            errors   = 0;
            clear_frame();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_STX_CHAR:      cfg.stx_char        = data[7:0];
                CFG_ETX_CHAR:      cfg.etx_char        = data[7:0];
                CFG_DLE_ENABLE:    cfg.dle_enable      = data[0];
                CFG_CR_STRIP:      cfg.cr_strip_enable = data[0];
                CFG_SOD_EOD_MODE:  cfg.sod_eod_mode    = data[0];
                CFG_SOD_EOD_TABLE: cfg.sod_eod_table   = data;
                default: ;
            endcase
        endfunction

        function int unsigned clip(int unsigned v);
            return (v > MAX_LEN) ? MAX_LEN : v;
        endfunction

        function void clear_frame();
            phase       = RX_HUNT;
            esc_pending = 1'b0;
            held        = 8'h00;
            held_ok     = 1'b0;
            count       = 0;
            np_pos      = 0;
        endfunction

        function void emit(logic [7:0] b, bit bv, bit fe, int unsigned len,
                           int unsigned pos, logic [1:0] ty, bit crd);
            t_result r;
            r.out_byte           = b;
            r.byte_valid         = bv;
            r.frame_end          = fe;
            r.frame_length       = len[LEN_W-1:0];
            r.first_nonprint_pos = pos[LEN_W-1:0];
            r.frame_type         = ty;
            r.cr_dropped         = crd;
            pending_results = {pending_results, r};
        endfunction

        function void store(logic [7:0] ch);
            if (np_pos == 0 && (ch < CH_PRINT_LO || ch > CH_PRINT_HI))
                np_pos = clip(count);
            if (held_ok)
                emit(held, 1'b1, 1'b0, 0, 0, 2'd0, 1'b0);
            held    = ch;
            held_ok = 1'b1;
            if (count < MAX_LEN + 1)
                count++;
            esc_pending = 1'b0;
        endfunction

        function void finish_frame();
            bit crd;
            crd = 1'b0;
            if (held_ok && cfg.cr_strip_enable && held == CH_CR) begin
                held_ok = 1'b0;
                count--;
                crd = 1'b1;
                if (np_pos == clip(count))
                    np_pos = 0;
            end
            if (held_ok)
                emit(held, 1'b1, 1'b1, clip(count), np_pos, ftype, crd);
            else
                emit(8'h00, 1'b0, 1'b1, clip(count), np_pos, ftype, crd);
            clear_frame();
        endfunction

        function void take_byte(logic [7:0] ch);
            logic [7:0] sc;
            logic [7:0] ec;
            bit         found;
            found = 1'b0;
            case (phase)
                RX_HUNT: begin
                    if (cfg.sod_eod_mode) begin
                        for (int i = 0; i < DEV_TYPES; i++) begin
                            sc = cfg.sod_eod_table[16*i +: 8];
                            ec = cfg.sod_eod_table[16*i+8 +: 8];
                            if (!found && ec != 8'h00 && sc == ch) begin
                                found    = 1'b1;
                                end_code = ec;
                                ftype    = i[1:0];
                                phase    = RX_WAIT_STX;
                            end
                        end
                    end else if (ch == cfg.stx_char) begin
                        ftype = 2'd0;
                        phase = RX_BODY;
                    end
                end
                RX_WAIT_STX: begin
                    if (ch == cfg.stx_char)
                        phase = RX_BODY;
                end
                RX_BODY: begin
                    if (ch == cfg.etx_char && !esc_pending) begin
                        if (cfg.sod_eod_mode)
                            phase = RX_WAIT_EOD;
                        else
                            finish_frame();
                    end else if (cfg.dle_enable && !esc_pending && ch == CH_DLE) begin
                        esc_pending = 1'b1;
                    end else begin
                        store(ch);
                    end
                end
                default: begin
                    if (ch == end_code)
                        finish_frame();
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare(string name, logic [LEN_W-1:0] got, logic [LEN_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result byte %02h valid %0b end %0b",
                                 got.out_byte, got.byte_valid, got.frame_end));
                return;
            end
            want = pending_results.pop_front();
            compare("out_byte", LEN_W'(got.out_byte), LEN_W'(want.out_byte));
            compare("byte_valid", LEN_W'(got.byte_valid), LEN_W'(want.byte_valid));
            compare("frame_end", LEN_W'(got.frame_end), LEN_W'(want.frame_end));
            compare("frame_length", got.frame_length, want.frame_length);
            compare("first_nonprint_pos", got.first_nonprint_pos, want.first_nonprint_pos);
            compare("frame_type", LEN_W'(got.frame_type), LEN_W'(want.frame_type));
            compare("cr_dropped", LEN_W'(got.cr_dropped), LEN_W'(want.cr_dropped));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [63:0]            i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [7:0]             i_rx_byte = 8'h00;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [7:0]             o_out_byte;
    logic                   o_byte_valid;
    logic                   o_frame_end;
    logic [LEN_W-1:0]       o_frame_length;
    logic [LEN_W-1:0]       o_first_nonprint_pos;
    logic [1:0]             o_frame_type;
    logic                   o_cr_dropped;

    deframe_scoreboard sb = new();
    logic [7:0]        burst[$];
    bit                calm = 1'b0;
    int                items_sent = 0;

    dle_frame_receiver #(
        .MAX_FRAME_LEN(MAX_LEN),
        .DEVICE_TYPES (DEV_TYPES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_byte          (o_out_byte),
        .o_byte_valid        (o_byte_valid),
        .o_frame_end         (o_frame_end),
        .o_frame_length      (o_frame_length),
        .o_first_nonprint_pos(o_first_nonprint_pos),
        .o_frame_type        (o_frame_type),
        .o_cr_dropped        (o_cr_dropped)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(t_result'({o_out_byte, o_byte_valid, o_frame_end,
                                       o_frame_length, o_first_nonprint_pos,
                                       o_frame_type, o_cr_dropped}));
        i_out_ready <= calm || ($urandom_range(99) >= 11);
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.take_byte(b);
        items_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[k])
            send_byte(burst[k]);
        burst.delete();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all results, then let bytes that make none leave the pipeline
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_char();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: v[7:0] = 8'h00;
            1: v[7:0] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    // queue one frame in the current settings: start code, STX, escaped body, ETX, end code
    task automatic add_frame(input int body_len, input bit end_cr, input bit print_only,
                             input int np_at);
        int         valid_ix[$];
        int         pick;
        logic [7:0] b;
        logic [7:0] stx;
        logic [7:0] etx;
        logic [7:0] ec;
        bit         can_esc;
        stx     = sb.cfg.stx_char;
        etx     = sb.cfg.etx_char;
        can_esc = sb.cfg.dle_enable && etx != CH_DLE;
        pick    = -1;
        if (sb.cfg.sod_eod_mode) begin
            for (int i = 0; i < DEV_TYPES; i++)
                if (sb.cfg.sod_eod_table[16*i+8 +: 8] != 8'h00)
                    valid_ix = {valid_ix, i};
            if (valid_ix.size() != 0) begin
                pick = valid_ix[$urandom_range(valid_ix.size() - 1)];
                burst = {burst, sb.cfg.sod_eod_table[16*pick +: 8]};
            end
            b = 8'($urandom_range(255));
            if ($urandom_range(3) == 0 && b != stx)
                burst = {burst, b};
        end
        burst = {burst, stx};
        for (int k = 0; k < body_len; k++) begin
            if (end_cr && k == body_len - 1)
                b = CH_CR;
            else if (print_only && k != np_at)
                b = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
            else
                b = 8'($urandom_range(255));
            if (b == etx || (sb.cfg.dle_enable && b == CH_DLE)
                    || (can_esc && $urandom_range(19) == 0)) begin
                if (can_esc)
                    burst = {burst, CH_DLE};
                else
                    b = b ^ 8'h01;
            end
            burst = {burst, b};
        end
        burst = {burst, etx};
        if (pick >= 0) begin
            ec = sb.cfg.sod_eod_table[16*pick+8 +: 8];
            b  = 8'($urandom_range(255));
            if ($urandom_range(3) == 0 && b != ec)
                burst = {burst, b};
            burst = {burst, ec};
        end
    endtask

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          phase_no;
        int          body_len;
        int          roll;
        logic [63:0] v;
        logic [63:0] tbl;

        phase_no  = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero quirk, field extremes, escaped ETX, then an empty frame
        burst = {RST_STX_CHAR, 8'h00, 8'hFF, 8'h20, 8'h7E, 8'h1F, 8'h7F, CH_DLE,
                 RST_ETX_CHAR, RST_ETX_CHAR, RST_STX_CHAR, RST_ETX_CHAR};
        send_burst();
        settle();
        write_reg(CFG_CR_STRIP, 64'h1);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, 64'h0);
        // escape pending across a DLE disable, then a trailing CR
        burst = {RST_STX_CHAR, CH_DLE};
        send_burst();
        settle();
        write_reg(CFG_DLE_ENABLE, 64'h0);
        burst = {RST_ETX_CHAR, CH_CR, RST_ETX_CHAR};
        send_burst();
        settle();
        // unused entry, first match among duplicates, mode drop while waiting for end code
        write_reg(CFG_SOD_EOD_TABLE, 64'hFFFF_5541_5A41_0041);
        write_reg(CFG_SOD_EOD_MODE, 64'h1);
        burst = {8'h41, RST_STX_CHAR, 8'h78, RST_ETX_CHAR, 8'h71};
        send_burst();
        settle();
        write_reg(CFG_SOD_EOD_MODE, 64'h0);
        burst = {8'h5A};
        send_burst();
        settle();

        while (items_sent < ITEM_GOAL) begin
            calm = (phase_no == 2);

            write_reg(CFG_STX_CHAR, pick_char());
            write_reg(CFG_ETX_CHAR, pick_char());
            write_reg(CFG_DLE_ENABLE, {$urandom, $urandom});
            v = {$urandom, $urandom};
            write_reg(CFG_CR_STRIP, v);
            tbl = {$urandom, $urandom};
            for (int e = 0; e < DEV_TYPES; e++)
                if ($urandom_range(3) == 0)
                    tbl[16*e+8 +: 8] = 8'h00;
            if ($urandom_range(4) == 0)
                tbl[23:16] = tbl[7:0];
            if ($urandom_range(9) == 0)
                tbl = '1;
            write_reg(CFG_SOD_EOD_TABLE, tbl);
            write_reg(CFG_SOD_EOD_MODE, {$urandom, $urandom});
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});

            repeat ($urandom_range(16, 4)) begin
                roll = $urandom_range(99);
                if (roll < 93) begin
                    body_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1);
                    add_frame(body_len, body_len > 0 && $urandom_range(3) == 0,
                              $urandom_range(2) == 0, $urandom_range(body_len));
                    // cut some frames short
                    if (roll >= 85)
                        repeat ($urandom_range(3, 1))
                            if (burst.size() > 0)
                                burst = burst[0:$-1];
                    send_burst();
                end else begin
                    repeat ($urandom_range(10, 1))
                        send_byte(8'($urandom_range(255)));
                end
            end
            settle();
            phase_no++;
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
